// File: rtl/ols_pkg.sv
// Shared types, codes and constants for the ordered list store.
package ols_pkg;

  localparam int DEFAULT_CAPACITY = 32;
  localparam int VALUE_W          = 32;
  localparam int POS_W            = 6;
  localparam int OP_W             = 4;
  localparam int STATUS_W         = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FIRST = 4'd0,
    OP_INS_LAST  = 4'd1,
    OP_INS_AT    = 4'd2,
    OP_DEL_FIRST = 4'd3,
    OP_DEL_LAST  = 4'd4,
    OP_DEL_AT    = 4'd5,
    OP_COUNT     = 4'd6,
    OP_SEARCH    = 4'd7,
    OP_DUMP      = 4'd8
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK_UP,
    S_WALK_DN,
    S_DRAIN,
    S_DONE
  } state_t;

  // Memory port strobes
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // One result transaction before the output register
  typedef struct packed {
    logic                      valid;
    status_t                   status;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          pos;
    logic [POS_W-1:0]          count;
    logic                      last;
  } res_t;

endpackage

// File: rtl/ols_mem.sv
// Entry store: one write port and one registered read port.
module ols_mem #(
  parameter int CAPACITY = ols_pkg::DEFAULT_CAPACITY,
  parameter int IDX_W    = $clog2(CAPACITY)
) (
  input  logic                               clk,
  input  ols_pkg::mem_ctl_t                  ctl,
  input  logic [IDX_W-1:0]                   waddr,
  input  logic signed [ols_pkg::VALUE_W-1:0] wdata,
  input  logic [IDX_W-1:0]                   raddr,
  output logic signed [ols_pkg::VALUE_W-1:0] rdata
);
  import ols_pkg::*;

  logic signed [VALUE_W-1:0] mem [CAPACITY];

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/ols_seq.sv
// Sequencer: request decode, entry walk over the store, shared compare.
module ols_seq #(
  parameter int CAPACITY = ols_pkg::DEFAULT_CAPACITY,
  parameter int IDX_W    = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [ols_pkg::OP_W-1:0]           opcode,
  input  logic signed [ols_pkg::VALUE_W-1:0] value,
  input  logic [ols_pkg::POS_W-1:0]          position,
  output logic                               busy,
  output ols_pkg::res_t                      res,
  output ols_pkg::mem_ctl_t                  mem_ctl,
  output logic [IDX_W-1:0]                   waddr,
  output logic signed [ols_pkg::VALUE_W-1:0] wdata,
  output logic [IDX_W-1:0]                   raddr,
  input  logic signed [ols_pkg::VALUE_W-1:0] rdata
);
  import ols_pkg::*;

  state_t                    state, state_next;
  op_t                       op_q;
  logic signed [VALUE_W-1:0] val_q;
  logic signed [VALUE_W-1:0] removed;
  logic [IDX_W-1:0]          idx_q;
  logic [IDX_W-1:0]          ptr;
  logic [IDX_W-1:0]          rd_addr;
  logic                      rd_pending;
  logic [CNT_W-1:0]          held;
  logic [CNT_W-1:0]          hits;

  logic                      accept;
  op_t                       op_in;
  logic                      is_ins, is_del, is_scan;
  logic                      full, empty, ins_bad, del_bad;
  logic [IDX_W-1:0]          idx_in;
  logic [IDX_W-1:0]          tail_idx;
  logic [POS_W:0]            held_ext;
  logic                      q_ins, q_del;
  logic                      hit;
  logic [POS_W-1:0]          rd_pos;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign op_in    = op_t'(opcode);
  assign held_ext = (POS_W + 1)'(held);
  assign tail_idx = IDX_W'(held - CNT_W'(1));
  assign full     = (held == CNT_W'(CAPACITY));
  assign empty    = (held == '0);
  assign is_ins   = (op_in == OP_INS_FIRST) || (op_in == OP_INS_LAST) || (op_in == OP_INS_AT);
  assign is_del   = (op_in == OP_DEL_FIRST) || (op_in == OP_DEL_LAST) || (op_in == OP_DEL_AT);
  assign is_scan  = (op_in == OP_SEARCH) || (op_in == OP_DUMP);
  assign ins_bad  = (op_in == OP_INS_AT) &&
                    ((position == '0) || ((POS_W + 1)'(position) > held_ext + 7'd1));
  assign del_bad  = (op_in == OP_DEL_AT) &&
                    ((position == '0) || ((POS_W + 1)'(position) > held_ext));
  assign q_ins    = (op_q == OP_INS_FIRST) || (op_q == OP_INS_LAST) || (op_q == OP_INS_AT);
  assign q_del    = (op_q == OP_DEL_FIRST) || (op_q == OP_DEL_LAST) || (op_q == OP_DEL_AT);
  // Shared compare unit: one stored entry against the search key per cycle
  assign hit      = (rdata == val_q);
  assign rd_pos   = POS_W'(rd_addr) + POS_W'(1);

  // Target index of the request
  always_comb begin
    unique case (op_in)
      OP_INS_LAST:            idx_in = IDX_W'(held);
      OP_DEL_LAST:            idx_in = tail_idx;
      OP_INS_AT, OP_DEL_AT:   idx_in = IDX_W'(position - POS_W'(1));
      default:                idx_in = '0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_ins && !full && !ins_bad) begin
            state_next = (idx_in == IDX_W'(held)) ? S_DONE : S_WALK_UP;
          end else if (is_del && !empty && !del_bad) begin
            state_next = S_WALK_DN;
          end else if (is_scan && !empty) begin
            state_next = S_WALK_DN;
          end
        end
      end
      S_WALK_UP: begin
        if (ptr == idx_q) state_next = S_DRAIN;
      end
      S_WALK_DN: begin
        if (ptr == tail_idx) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = (op_q == OP_DUMP) ? S_IDLE : S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Memory strobes, shift writes and result transactions
  always_comb begin
    mem_ctl.re = (state == S_WALK_UP) || (state == S_WALK_DN);
    mem_ctl.we = 1'b0;
    raddr      = ptr;
    waddr      = rd_addr;
    wdata      = rdata;
    res        = '0;
    res.status = ST_OK;

    // Move a returned entry one place up or down
    if (rd_pending) begin
      if (q_ins) begin
        mem_ctl.we = 1'b1;
        waddr      = rd_addr + IDX_W'(1);
      end else if (q_del && (rd_addr != idx_q)) begin
        mem_ctl.we = 1'b1;
        waddr      = rd_addr - IDX_W'(1);
      end
    end

    // Drop the new value into its slot
    if ((state == S_DONE) && q_ins) begin
      mem_ctl.we = 1'b1;
      waddr      = idx_q;
      wdata      = val_q;
    end

    // Immediate replies
    if ((state == S_IDLE) && accept) begin
      res.last  = 1'b1;
      res.count = POS_W'(held);
      if (is_ins && full) begin
        res.valid  = 1'b1;
        res.status = ST_FULL;
      end else if (is_ins && ins_bad) begin
        res.valid  = 1'b1;
        res.status = ST_BADPOS;
      end else if ((is_del || is_scan) && empty) begin
        res.valid  = 1'b1;
        res.status = ST_EMPTY;
      end else if (is_del && del_bad) begin
        res.valid  = 1'b1;
        res.status = ST_BADPOS;
      end else if (op_in == OP_COUNT) begin
        res.valid  = 1'b1;
      end
    end

    // Per-entry results of search and dump
    if (rd_pending && (op_q == OP_SEARCH) && hit) begin
      res.valid = 1'b1;
      res.pos   = rd_pos;
    end
    if (rd_pending && (op_q == OP_DUMP)) begin
      res.valid = 1'b1;
      res.value = rdata;
      res.pos   = rd_pos;
      res.count = POS_W'(held);
      res.last  = (rd_addr == tail_idx);
    end

    // Closing result
    if (state == S_DONE) begin
      res.valid = 1'b1;
      res.last  = 1'b1;
      if (q_ins) begin
        res.count = POS_W'(held) + POS_W'(1);
      end else if (q_del) begin
        res.value = removed;
        res.count = POS_W'(held) - POS_W'(1);
      end else begin
        res.count = POS_W'(hits);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held       <= '0;
      rd_pending <= 1'b0;
      op_q       <= OP_COUNT;
      hits       <= '0;
    end else begin
      state      <= state_next;
      rd_pending <= mem_ctl.re;
      if (accept) begin
        op_q <= op_in;
        hits <= '0;
      end
      if (rd_pending && (op_q == OP_SEARCH) && hit) begin
        hits <= hits + CNT_W'(1);
      end
      if (state == S_DONE) begin
        if (q_ins) begin
          held <= held + CNT_W'(1);
        end else if (q_del) begin
          held <= held - CNT_W'(1);
        end
      end
    end
  end

  // Request payload and walk pointer
  always_ff @(posedge clk) begin
    rd_addr <= ptr;
    if (accept) begin
      val_q <= value;
      idx_q <= idx_in;
      ptr   <= is_ins ? tail_idx : (is_del ? idx_in : '0);
    end else if (state == S_WALK_UP) begin
      ptr <= ptr - IDX_W'(1);
    end else if (state == S_WALK_DN) begin
      ptr <= ptr + IDX_W'(1);
    end
    if (rd_pending && q_del && (rd_addr == idx_q)) begin
      removed <= rdata;
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_read_from_walk: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> ($past(state) == S_WALK_UP) || ($past(state) == S_WALK_DN))
    else $error("read data returned without a walk");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.last) |=> (state == S_IDLE))
    else $error("sequencer still busy after final result");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.we |-> (CNT_W'(waddr) <= held))
    else $error("write beyond the held entries");

endmodule

// File: rtl/ordered_list_store.sv
// Ordered list store: a packed store of signed entries with positional edits.
// Count and refused requests leave busy low; the registered result follows in the next cycle.
// Insert or delete at index i walks the entries between i and the back of the list, one entry
// moved per cycle through the single read and single write port of the entry store;
// an insert at the back skips the walk.
// Search and dump walk every held entry, one entry compared or sent a cycle.
// Synchronous reset empties the list at once; results cannot be stalled by the receiver.
module ordered_list_store #(
  parameter int CAPACITY = ols_pkg::DEFAULT_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [ols_pkg::OP_W-1:0]            opcode,
  input  logic signed [ols_pkg::VALUE_W-1:0]  value,
  input  logic [ols_pkg::POS_W-1:0]           position,
  output logic                                strobe,
  output logic [ols_pkg::STATUS_W-1:0]        status,
  output logic signed [ols_pkg::VALUE_W-1:0]  item_value,
  output logic [ols_pkg::POS_W-1:0]           item_position,
  output logic [ols_pkg::POS_W-1:0]           entry_count,
  output logic                                last_result
);
  import ols_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  mem_ctl_t                  mem_ctl;
  logic [IDX_W-1:0]          waddr, raddr;
  logic signed [VALUE_W-1:0] wdata, rdata;
  res_t                      res;

  ols_seq #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .opcode   (opcode),
    .value    (value),
    .position (position),
    .busy     (busy),
    .res      (res),
    .mem_ctl  (mem_ctl),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  ols_mem #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Register the result transaction strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= res.valid;
    end
  end

  // Register the result payload
  always_ff @(posedge clk) begin
    status        <= res.status;
    item_value    <= res.value;
    item_position <= res.pos;
    entry_count   <= res.count;
    last_result   <= res.last;
  end

endmodule
